FILE: src/wtsg_pkg.sv
// wtsg_pkg: shared types and constants of the wavetable sound generator
// used by wtsg_mul and wavetable_sound_generator, depends on nothing
package wtsg_pkg;

    localparam int VOICES       = 3;
    localparam int VOICE_W      = $clog2(VOICES);
    localparam int WAVE_LENGTH  = 32;
    localparam int POS_W        = $clog2(WAVE_LENGTH);
    localparam int REG_COUNT    = 32;
    localparam int REG_AW       = $clog2(REG_COUNT);
    localparam int NIB_W        = 4;
    localparam int FREQ_W       = 20;
    localparam int PHASE_W      = 32;
    localparam int SCALE_W      = 16;
    localparam int SAMPLE_W     = 16;
    localparam int WAVE_W       = 8;
    localparam int ADDR_W       = 9;
    localparam int ACC_W        = 14;

    localparam int MUL_A_W      = FREQ_W + 1;
    localparam int MUL_B_W      = SCALE_W + 1;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    localparam int VOL_BASE     = 'h15;
    localparam int SEL_BASE     = 'h05;
    localparam int FREQ_BASE    = 'h11;
    localparam int FREQ_LOW     = 'h10;
    localparam int VOICE_STRIDE = 5;

    localparam logic [SCALE_W-1:0]         STEP_RESET = 16'd8192;
    localparam logic signed [MUL_B_W-1:0]  GAIN       = 17'sd48;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_REG  = 2'd1,
        CMD_WAVE = 2'd2
    } t_cmd;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ACC  = 8'b0000_1000,
        S_GAIN = 8'b0001_0000,
        S_SAT  = 8'b0010_0000,
        S_PMUL = 8'b0100_0000,
        S_PADD = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic                       en;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } t_mul_req;

endpackage

FILE: src/wtsg_mul.sv
// wtsg_mul: shared signed multiplier with a registered product
// depends on wtsg_pkg
module wtsg_mul (
    input  logic                                   i_clk,
    input  wtsg_pkg::t_mul_req                     i_req,
    output logic signed [wtsg_pkg::PROD_W-1:0]     o_prod
);

    logic signed [wtsg_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= wtsg_pkg::PROD_W'(i_req.a) * wtsg_pkg::PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: src/wavetable_sound_generator.sv
// wavetable_sound_generator: three-voice wavetable mixer, top level
// depends on wtsg_pkg and wtsg_mul
//
// input beats on s_axis: tuser holds the command, tdata the address and data.
// a register write or a wave byte write gives no result.
// a tick runs the voices through one shared multiplier: per voice a wave
// read, a multiply and an accumulate, then the gain multiply and saturation,
// then per voice a phase step multiply and add; the sample is loaded into
// the output register in the saturation step, and the block is ready again after the last add.
// s_axis_tready is low while a tick is being worked on.
// the sample waits in an output register; if it is still untaken when the
// next tick reaches saturation, the sequencer holds there until it goes.
// i_cfg_we writes step_scale at once; write it only while the block is idle.
// after reset: all sound registers zero, phases zero, step_scale 8192;
// the wave memory holds nothing defined and must be loaded before use.
module wavetable_sound_generator #(
    parameter int WAVE_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wtsg_pkg::SCALE_W-1:0]      i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // address[8:0], data[16:9], zero
    input  logic [1:0]                        s_axis_tuser,  // command[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wtsg_pkg::SAMPLE_W-1:0]     m_axis_tdata   // sample[15:0]
);

    localparam int WAVE_CELLS = WAVE_COUNT * wtsg_pkg::WAVE_LENGTH;
    localparam int MEM_AW     = $clog2(WAVE_CELLS);

    wtsg_pkg::t_state                           r_state, n_state;
    logic [wtsg_pkg::VOICE_W-1:0]               r_voice, n_voice;
    logic [wtsg_pkg::NIB_W-1:0]                 r_sreg [wtsg_pkg::REG_COUNT];
    logic [wtsg_pkg::PHASE_W-1:0]               r_phase [wtsg_pkg::VOICES];
    logic [wtsg_pkg::SCALE_W-1:0]               r_scale;
    logic signed [wtsg_pkg::ACC_W-1:0]          r_acc, n_acc;
    logic                                       r_out_valid;
    logic [wtsg_pkg::SAMPLE_W-1:0]              r_out_data;
    logic signed [wtsg_pkg::WAVE_W-1:0]         r_mem [WAVE_CELLS];
    logic signed [wtsg_pkg::WAVE_W-1:0]         r_rdata;
    logic                                       r_silent;

    logic [wtsg_pkg::NIB_W-1:0]                 w_vol  [wtsg_pkg::VOICES];
    logic [wtsg_pkg::NIB_W-1:0]                 w_sel  [wtsg_pkg::VOICES];
    logic [wtsg_pkg::FREQ_W-1:0]                w_freq [wtsg_pkg::VOICES];

    logic                                       w_in_beat;
    wtsg_pkg::t_cmd                             w_cmd;
    logic [wtsg_pkg::ADDR_W-1:0]                w_addr;
    logic [wtsg_pkg::WAVE_W-1:0]                w_data;
    logic                                       w_reg_wr;
    logic                                       w_wave_wr;
    logic [wtsg_pkg::POS_W-1:0]                 w_pos;
    logic [MEM_AW-1:0]                          w_rd_idx;
    logic                                       w_out_free;
    logic                                       w_out_load;
    logic signed [wtsg_pkg::SAMPLE_W-1:0]       w_sat;
    wtsg_pkg::t_mul_req                         w_req;
    logic signed [wtsg_pkg::PROD_W-1:0]         w_prod;

    for (genvar v = 0; v < wtsg_pkg::VOICES; v++) begin : g_voice
        localparam logic [wtsg_pkg::REG_AW-1:0] VA =
            wtsg_pkg::REG_AW'(wtsg_pkg::VOL_BASE + wtsg_pkg::VOICE_STRIDE * v);
        localparam logic [wtsg_pkg::REG_AW-1:0] SA =
            wtsg_pkg::REG_AW'(wtsg_pkg::SEL_BASE + wtsg_pkg::VOICE_STRIDE * v);
        localparam logic [wtsg_pkg::REG_AW-1:0] FA =
            wtsg_pkg::REG_AW'(wtsg_pkg::FREQ_BASE + wtsg_pkg::VOICE_STRIDE * v);
        localparam logic [wtsg_pkg::REG_AW-1:0] FL =
            wtsg_pkg::REG_AW'(wtsg_pkg::FREQ_LOW);
        logic [wtsg_pkg::NIB_W-1:0] w_low;

        assign w_low    = (v == 0) ? r_sreg[FL] : '0;
        assign w_vol[v] = r_sreg[VA];
        assign w_sel[v] = r_sreg[SA];
        assign w_freq[v] = (r_sreg[VA] == '0) ? '0 :
            {r_sreg[FA + 3'd3], r_sreg[FA + 3'd2], r_sreg[FA + 3'd1], r_sreg[FA], w_low};
    end

    assign s_axis_tready = (r_state == wtsg_pkg::S_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = wtsg_pkg::t_cmd'(s_axis_tuser);
    assign w_addr        = s_axis_tdata[8:0];
    assign w_data        = s_axis_tdata[16:9];
    assign w_reg_wr      = w_in_beat && (w_cmd == wtsg_pkg::CMD_REG)
                           && (w_addr[wtsg_pkg::ADDR_W-1:wtsg_pkg::REG_AW] == '0);
    assign w_wave_wr     = w_in_beat && (w_cmd == wtsg_pkg::CMD_WAVE)
                           && ({1'b0, w_addr} < 10'(WAVE_CELLS));

    assign w_pos    = r_phase[r_voice][wtsg_pkg::PHASE_W-1 -: wtsg_pkg::POS_W];
    assign w_rd_idx = MEM_AW'({w_sel[r_voice], w_pos});

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = (r_state == wtsg_pkg::S_SAT) && w_out_free;

    always_comb begin
        if (w_prod > wtsg_pkg::PROD_W'(wtsg_pkg::OUT_MAX)) begin
            w_sat = wtsg_pkg::OUT_MAX;
        end else if (w_prod < wtsg_pkg::PROD_W'(wtsg_pkg::OUT_MIN)) begin
            w_sat = wtsg_pkg::OUT_MIN;
        end else begin
            w_sat = w_prod[wtsg_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        w_req.en = 1'b0;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            wtsg_pkg::S_MUL: begin
                w_req.en = 1'b1;
                w_req.a  = r_silent ? '0 : wtsg_pkg::MUL_A_W'(r_rdata);
                w_req.b  = wtsg_pkg::MUL_B_W'({1'b0, w_vol[r_voice]});
            end
            wtsg_pkg::S_GAIN: begin
                w_req.en = 1'b1;
                w_req.a  = wtsg_pkg::MUL_A_W'(r_acc);
                w_req.b  = wtsg_pkg::GAIN;
            end
            wtsg_pkg::S_PMUL: begin
                w_req.en = 1'b1;
                w_req.a  = wtsg_pkg::MUL_A_W'({1'b0, w_freq[r_voice]});
                w_req.b  = wtsg_pkg::MUL_B_W'({1'b0, r_scale});
            end
            default: begin
                w_req.en = 1'b0;
            end
        endcase
    end

    wtsg_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        n_acc   = r_acc;
        case (r_state)
            wtsg_pkg::S_IDLE: begin
                if (w_in_beat && (w_cmd == wtsg_pkg::CMD_TICK)) begin
                    n_state = wtsg_pkg::S_RD;
                    n_voice = '0;
                    n_acc   = '0;
                end
            end
            wtsg_pkg::S_RD: begin
                n_state = wtsg_pkg::S_MUL;
            end
            wtsg_pkg::S_MUL: begin
                n_state = wtsg_pkg::S_ACC;
            end
            wtsg_pkg::S_ACC: begin
                n_acc = r_acc + w_prod[wtsg_pkg::ACC_W-1:0];
                if (r_voice == wtsg_pkg::VOICE_W'(wtsg_pkg::VOICES - 1)) begin
                    n_state = wtsg_pkg::S_GAIN;
                    n_voice = '0;
                end else begin
                    n_state = wtsg_pkg::S_RD;
                    n_voice = r_voice + 1'b1;
                end
            end
            wtsg_pkg::S_GAIN: begin
                n_state = wtsg_pkg::S_SAT;
            end
            wtsg_pkg::S_SAT: begin
                if (w_out_free) begin
                    n_state = wtsg_pkg::S_PMUL;
                end
            end
            wtsg_pkg::S_PMUL: begin
                n_state = wtsg_pkg::S_PADD;
            end
            wtsg_pkg::S_PADD: begin
                if (r_voice == wtsg_pkg::VOICE_W'(wtsg_pkg::VOICES - 1)) begin
                    n_state = wtsg_pkg::S_IDLE;
                    n_voice = '0;
                end else begin
                    n_state = wtsg_pkg::S_PMUL;
                    n_voice = r_voice + 1'b1;
                end
            end
            default: begin
                n_state = wtsg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wtsg_pkg::S_IDLE;
            r_voice     <= '0;
            r_acc       <= '0;
            r_scale     <= wtsg_pkg::STEP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < wtsg_pkg::REG_COUNT; i++) begin
                r_sreg[i] <= '0;
            end
            for (int i = 0; i < wtsg_pkg::VOICES; i++) begin
                r_phase[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_acc   <= n_acc;
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (w_reg_wr) begin
                r_sreg[w_addr[wtsg_pkg::REG_AW-1:0]] <= w_data[wtsg_pkg::NIB_W-1:0];
            end
            if (r_state == wtsg_pkg::S_PADD) begin
                r_phase[r_voice] <= r_phase[r_voice] + w_prod[wtsg_pkg::PHASE_W-1:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_sat;
        end
        if (r_state == wtsg_pkg::S_RD) begin
            r_silent <= ({1'b0, w_sel[r_voice]} >= 5'(WAVE_COUNT));
        end
    end

    // wave memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wave_wr) begin
            r_mem[MEM_AW'(w_addr)] <= w_data;
        end
        if (r_state == wtsg_pkg::S_RD) begin
            r_rdata <= r_mem[w_rd_idx];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && (w_cmd == wtsg_pkg::CMD_TICK)) |=> !s_axis_tready)
        else $error("tick beat did not take the block busy");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && (w_cmd != wtsg_pkg::CMD_TICK)) |=> s_axis_tready)
        else $error("write beat left the block busy");

    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_voice <= wtsg_pkg::VOICE_W'(wtsg_pkg::VOICES - 1))
        else $error("voice counter out of range");

    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wtsg_pkg::S_SAT) && r_out_valid && !m_axis_tready)
        |=> ((r_state == wtsg_pkg::S_SAT) && $stable(r_out_data)))
        else $error("pending sample overwritten");

    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == wtsg_pkg::S_SAT))
        else $error("sample beat raised outside saturation step");
`endif

endmodule

FILE: sim/tb_mix_checker.sv
// tb_mix_checker: watches the config port and both stream channels of the wavetable
// sound generator, predicts every sample from its own voice model and compares
// depends on wtsg_pkg for widths, command codes and the sound register map
module tb_mix_checker #(
    parameter int WAVE_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wtsg_pkg::SCALE_W-1:0]  i_cfg_wdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [23:0]                   i_s_tdata,   // address[8:0], data[16:9], zero
    input  logic [1:0]                    i_s_tuser,   // command[1:0]
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [wtsg_pkg::SAMPLE_W-1:0] i_m_tdata,   // sample[15:0]
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAVE_CELLS = WAVE_COUNT * wtsg_pkg::WAVE_LENGTH;

    logic [wtsg_pkg::NIB_W-1:0]          sound_nib [wtsg_pkg::REG_COUNT];
    logic signed [wtsg_pkg::WAVE_W-1:0]  wave_byte [WAVE_CELLS];
    logic [wtsg_pkg::PHASE_W-1:0]        phase_acc [wtsg_pkg::VOICES];
    logic [wtsg_pkg::SCALE_W-1:0]        step_scale;
    logic [wtsg_pkg::SAMPLE_W-1:0]       samples_due [$];
    int                                  fail_count = 0;

    // mixes the voices for one tick, then steps the phases
    function automatic logic [wtsg_pkg::SAMPLE_W-1:0] mix_voices();
        int                                 acc;
        int                                 vol;
        int                                 sel;
        int                                 fa;
        logic [wtsg_pkg::FREQ_W-1:0]        freq;
        logic [63:0]                        step;
        logic [wtsg_pkg::SAMPLE_W-1:0]      sample;
        acc = 0;
        for (int v = 0; v < wtsg_pkg::VOICES; v++) begin
            vol = sound_nib[wtsg_pkg::VOL_BASE + wtsg_pkg::VOICE_STRIDE * v];
            sel = sound_nib[wtsg_pkg::SEL_BASE + wtsg_pkg::VOICE_STRIDE * v];
            if (vol != 0 && sel < WAVE_COUNT) begin
                acc += vol * int'(wave_byte[sel * wtsg_pkg::WAVE_LENGTH
                                            + phase_acc[v][31:27]]);
            end
        end
        acc *= 48;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        sample = acc[wtsg_pkg::SAMPLE_W-1:0];
        for (int v = 0; v < wtsg_pkg::VOICES; v++) begin
            freq = '0;
            fa   = wtsg_pkg::FREQ_BASE + wtsg_pkg::VOICE_STRIDE * v;
            if (sound_nib[wtsg_pkg::VOL_BASE + wtsg_pkg::VOICE_STRIDE * v] != 0) begin
                freq[19:4] = {sound_nib[fa + 3], sound_nib[fa + 2],
                              sound_nib[fa + 1], sound_nib[fa]};
                if (v == 0) freq[3:0] = sound_nib[wtsg_pkg::FREQ_LOW];
            end
            step = 64'(freq) * 64'(step_scale);
            phase_acc[v] = phase_acc[v] + step[wtsg_pkg::PHASE_W-1:0];
        end
        return sample;
    endfunction

    task automatic flag_fault(input string what,
                              input logic [wtsg_pkg::SAMPLE_W-1:0] want,
                              input logic [wtsg_pkg::SAMPLE_W-1:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what,
                     $signed(want), $signed(got));
        end
    endtask

    always @(posedge i_clk) begin
        logic [wtsg_pkg::ADDR_W-1:0]   addr;
        logic [wtsg_pkg::WAVE_W-1:0]   data;
        logic [wtsg_pkg::SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            foreach (sound_nib[i]) sound_nib[i] = '0;
            foreach (phase_acc[i]) phase_acc[i] = '0;
            step_scale = wtsg_pkg::STEP_RESET;
            samples_due.delete();
        end else begin
            if (i_cfg_we) step_scale = i_cfg_wdata;
            // results first: an output beat always belongs to an earlier tick
            if (i_m_tvalid && i_m_tready) begin
                if (samples_due.size() == 0) begin
                    flag_fault("sample beat with no tick pending", '0, i_m_tdata);
                end else begin
                    want = samples_due.pop_front();
                    if (i_m_tdata !== want) flag_fault("sample mismatch", want, i_m_tdata);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                addr = i_s_tdata[8:0];
                data = i_s_tdata[16:9];
                case (i_s_tuser)
                    wtsg_pkg::CMD_TICK: samples_due.push_back(mix_voices());
                    wtsg_pkg::CMD_REG: begin
                        if (addr < wtsg_pkg::REG_COUNT) begin
                            sound_nib[addr[wtsg_pkg::REG_AW-1:0]] = data[3:0];
                        end
                    end
                    wtsg_pkg::CMD_WAVE: if (addr < WAVE_CELLS) wave_byte[addr] = data;
                    default: ;
                endcase
            end
        end
        o_pending    <= samples_due.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: sim/tb_top.sv
// tb_top: stimulus and verdict for the wavetable sound generator
// drives random stream traffic and step scale settings, depends on wtsg_pkg,
// wavetable_sound_generator and tb_mix_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WAVE_COUNT  = 8;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          SETTLE      = 24;
    localparam int          PHASE_ITEMS = 32;
    localparam int          CYCLE_LIMIT = 400000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [wtsg_pkg::SCALE_W-1:0]   cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [23:0]                    s_tdata;   // address[8:0], data[16:9], zero
    logic [1:0]                     s_tuser;   // command[1:0]
    logic                           m_tvalid;
    logic                           m_tready;
    logic [wtsg_pkg::SAMPLE_W-1:0]  m_tdata;   // sample[15:0]
    int                             faults;
    int                             pending;
    int                             cycles = 0;
    bit                             send_steady = 1'b0;
    bit                             take_steady = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    wavetable_sound_generator #(
        .WAVE_COUNT (WAVE_COUNT)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    tb_mix_checker #(
        .WAVE_COUNT (WAVE_COUNT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (faults),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] cmd,
                             input logic [wtsg_pkg::ADDR_W-1:0] addr,
                             input logic [wtsg_pkg::WAVE_W-1:0] data);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 19) == 0) send_steady = !send_steady;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, data, addr};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic reg_write(input int idx, input logic [wtsg_pkg::WAVE_W-1:0] data);
        send_beat(wtsg_pkg::CMD_REG, wtsg_pkg::ADDR_W'(idx), data);
    endtask

    // hold off until every sample has arrived and the sequencer has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_step_scale(input logic [wtsg_pkg::SCALE_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic [wtsg_pkg::SCALE_W-1:0] scale);
        int                          counted;
        int                          pick;
        logic [wtsg_pkg::ADDR_W-1:0] addr;
        logic [wtsg_pkg::WAVE_W-1:0] data;
        set_step_scale(scale);
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            addr = $urandom_range(0, 511);
            data = $urandom_range(0, 255);
            if (pick < 40) begin
                send_beat(wtsg_pkg::CMD_TICK, addr, data);
                counted++;
            end else if (pick < 75) begin
                if ($urandom_range(0, 9) != 0) addr = {4'b0, addr[4:0]};
                send_beat(wtsg_pkg::CMD_REG, addr, data);
                if (addr < wtsg_pkg::REG_COUNT) counted++;
            end else if (pick < 95) begin
                send_beat(wtsg_pkg::CMD_WAVE, addr, data);
                counted++;
            end else begin
                send_beat(CMD_UNUSED, addr, data);
            end
            if ($urandom_range(0, 59) == 0) drain();
        end
    endtask

    // receiver: random stalls before each sample beat, with stall-free stretches
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = take_steady ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 19) == 0) take_steady = !take_steady;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= wtsg_pkg::CMD_TICK;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full wave memory: wave 0 at the positive peak, wave 1 at the negative one
        for (int i = 0; i < WAVE_COUNT * wtsg_pkg::WAVE_LENGTH; i++) begin
            if (i < wtsg_pkg::WAVE_LENGTH) begin
                send_beat(wtsg_pkg::CMD_WAVE, wtsg_pkg::ADDR_W'(i), 8'h7F);
            end else if (i < 2 * wtsg_pkg::WAVE_LENGTH) begin
                send_beat(wtsg_pkg::CMD_WAVE, wtsg_pkg::ADDR_W'(i), 8'h80);
            end else begin
                send_beat(wtsg_pkg::CMD_WAVE, wtsg_pkg::ADDR_W'(i),
                          wtsg_pkg::WAVE_W'($urandom_range(0, 255)));
            end
        end

        set_step_scale(16'hFFFF);
        send_beat(wtsg_pkg::CMD_TICK, '0, '0);
        send_beat(CMD_UNUSED, 9'h1FF, 8'hFF);
        send_beat(wtsg_pkg::CMD_REG, 9'd32, 8'hFF);
        send_beat(wtsg_pkg::CMD_REG, 9'h1FF, 8'hFF);
        reg_write(wtsg_pkg::VOL_BASE, 8'hFF);
        reg_write(wtsg_pkg::SEL_BASE, 8'hF0);
        reg_write(wtsg_pkg::FREQ_LOW, 8'hFF);
        for (int n = 0; n < 4; n++) reg_write(wtsg_pkg::FREQ_BASE + n, 8'hFF);
        send_beat(wtsg_pkg::CMD_TICK, '0, '0);
        send_beat(wtsg_pkg::CMD_TICK, 9'h1FF, 8'hFF);
        for (int v = 1; v < wtsg_pkg::VOICES; v++) begin
            reg_write(wtsg_pkg::SEL_BASE + wtsg_pkg::VOICE_STRIDE * v, 8'h01);
            reg_write(wtsg_pkg::VOL_BASE + wtsg_pkg::VOICE_STRIDE * v, 8'h0F);
            reg_write(wtsg_pkg::FREQ_BASE + wtsg_pkg::VOICE_STRIDE * v + v, 8'h0F);
        end
        send_beat(wtsg_pkg::CMD_TICK, '0, '0);
        reg_write(wtsg_pkg::VOL_BASE, 8'h00);
        send_beat(wtsg_pkg::CMD_TICK, '0, '0);
        send_beat(wtsg_pkg::CMD_TICK, '0, '0);
        reg_write(wtsg_pkg::VOL_BASE, 8'h01);
        send_beat(wtsg_pkg::CMD_TICK, '0, '0);

        random_phase(16'd1);
        random_phase(16'd0);
        random_phase(wtsg_pkg::SCALE_W'($urandom_range(2, 65534)));
        random_phase(wtsg_pkg::STEP_RESET);

        drain();
        if (faults == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
